@@ rtl/core/fqr_pkg.sv @@
`timescale 1ns / 1ps

package fqr_pkg;

  // queue geometry
  localparam int Depth   = 16;
  localparam int HandleW = 32;
  localparam int CntW    = $clog2(Depth + 1);

  // widths of the command and result fields
  localparam int ActW    = 2;
  localparam int StatW   = 2;
  localparam int ItemW   = 32;
  localparam int CountW  = 5;

  typedef enum logic [ActW-1:0] {
    ACT_ENQ   = 2'd0,
    ACT_DEQ   = 2'd1,
    ACT_REM   = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // control broadcast to every cell during the execute cycle
  typedef struct packed {
    logic               enq;
    logic               deq;
    logic               rem;
    logic [HandleW-1:0] handle;
  } ctrl_t;

endpackage

@@ rtl/core/fifo_queue_with_remove_by_value.sv @@
`timescale 1ns / 1ps

// Ordered queue of handles with enqueue, dequeue, remove-by-value and query.
// Command channel: a beat is taken at a rising edge with start high and busy
// low; action_i and item_handle_i are sampled then. busy rises for the next
// cycle while the row of cells works on the command.
// Result channel: valid_o is high for exactly one cycle with status_o,
// item_out_o, count_o and is_empty_o. The receiver cannot stall; the beat is
// gone after that cycle.
// Timing: the result is shown in the cycle after the execute cycle. A new
// command may be given in the cycle the result is shown. In the execute
// cycle of a remove every cell compares its handle, the first-match flag
// ripples down the row and the cells behind the match shift toward the head.
// Reset: all cells are marked empty and the count cleared at once; no
// command is pending and no result is shown. Stored handles keep no reset.
// Full: an enqueue with all cells used returns the full status and leaves
// the queue as it was.
module fifo_queue_with_remove_by_value (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic [fqr_pkg::ActW-1:0]   action_i,
  input  logic [fqr_pkg::ItemW-1:0]  item_handle_i,
  output logic                       busy,
  output logic                       valid_o,
  output logic [fqr_pkg::StatW-1:0]  status_o,
  output logic [fqr_pkg::ItemW-1:0]  item_out_o,
  output logic [fqr_pkg::CountW-1:0] count_o,
  output logic                       is_empty_o
);

  localparam int Depth = fqr_pkg::Depth;

  logic                        busy_q, done_q;
  fqr_pkg::action_e            act_q;
  logic [fqr_pkg::HandleW-1:0] handle_q;
  logic [fqr_pkg::CntW-1:0]    count_q, count_d;
  fqr_pkg::status_e            status_q, status_d;
  logic [fqr_pkg::HandleW-1:0] item_q, item_d;
  logic                        accept;
  logic                        full;
  logic                        empty;
  fqr_pkg::ctrl_t              ctrl;

  logic [Depth:0]              seen;
  logic [Depth:0]              valid_chain;
  logic [fqr_pkg::HandleW-1:0] data_chain [Depth+1];
  logic [Depth-1:0]            valid_vec;

  assign accept = start & ~busy_q;
  assign full   = (count_q == fqr_pkg::CntW'(Depth));
  assign empty  = (count_q == '0);

  // command capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= fqr_pkg::action_e'(action_i);
      handle_q <= fqr_pkg::HandleW'(item_handle_i);
    end
  end

  // broadcast control, live only in the execute cycle
  always_comb begin
    ctrl.enq    = busy_q & (act_q == fqr_pkg::ACT_ENQ);
    ctrl.deq    = busy_q & (act_q == fqr_pkg::ACT_DEQ);
    ctrl.rem    = busy_q & (act_q == fqr_pkg::ACT_REM);
    ctrl.handle = handle_q;
  end

  // row of cells, head at index zero
  assign seen[0]            = ctrl.deq;
  assign valid_chain[Depth] = 1'b0;
  assign data_chain[Depth]  = '0;

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic prv_valid;
    if (k == 0) begin : g_head
      assign prv_valid = 1'b1;
    end else begin : g_body
      assign prv_valid = valid_chain[k-1];
    end

    fqr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prv_valid_i (prv_valid),
      .nxt_valid_i (valid_chain[k+1]),
      .nxt_data_i  (data_chain[k+1]),
      .seen_i      (seen[k]),
      .seen_o      (seen[k+1]),
      .valid_o     (valid_chain[k]),
      .data_o      (data_chain[k])
    );

    assign valid_vec[k] = valid_chain[k];
  end

  // result and count update
  always_comb begin
    status_d = fqr_pkg::ST_OK;
    item_d   = '0;
    count_d  = count_q;
    case (act_q)
      fqr_pkg::ACT_ENQ: begin
        if (full) begin
          status_d = fqr_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      fqr_pkg::ACT_DEQ: begin
        if (empty) begin
          status_d = fqr_pkg::ST_EMPTY;
        end else begin
          item_d  = data_chain[0];
          count_d = count_q - 1'b1;
        end
      end
      fqr_pkg::ACT_REM: begin
        if (empty) begin
          status_d = fqr_pkg::ST_EMPTY;
        end else if (seen[Depth]) begin
          count_d = count_q - 1'b1;
        end else begin
          status_d = fqr_pkg::ST_MISSING;
        end
      end
      default: begin
        status_d = fqr_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (busy_q) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_q <= status_d;
      item_q   <= item_d;
    end
  end

  assign busy       = busy_q;
  assign valid_o    = done_q;
  assign status_o   = status_q;
  assign item_out_o = fqr_pkg::ItemW'(item_q);
  assign count_o    = fqr_pkg::CountW'(count_q);
  assign is_empty_o = (count_q == '0);

  // occupied cells always match the count
  a_count_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("cell valid bits disagree with count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fqr_pkg::CntW'(Depth))
    else $error("count beyond depth");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> done_q && !busy_q)
    else $error("execute cycle not followed by a single result");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("result shown while a command executes");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && act_q == fqr_pkg::ACT_DEQ && !empty) |=> count_q == $past(count_q) - 1'b1)
    else $error("dequeue did not lower the count");

endmodule

@@ rtl/core/fqr_cell.sv @@
`timescale 1ns / 1ps

module fqr_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fqr_pkg::ctrl_t              ctrl_i,
  input  logic                        prv_valid_i,
  input  logic                        nxt_valid_i,
  input  logic [fqr_pkg::HandleW-1:0] nxt_data_i,
  input  logic                        seen_i,
  output logic                        seen_o,
  output logic                        valid_o,
  output logic [fqr_pkg::HandleW-1:0] data_o
);

  logic                        valid_q, valid_d;
  logic [fqr_pkg::HandleW-1:0] data_q, data_d;
  logic                        hit;
  logic                        take_nxt;
  logic                        load;

  // match against the broadcast handle, first hit marks the cells to collapse
  assign hit      = ctrl_i.rem & valid_q & (data_q == ctrl_i.handle);
  assign seen_o   = seen_i | hit;
  assign take_nxt = (ctrl_i.rem | ctrl_i.deq) & seen_o;
  // the first free cell takes an appended handle
  assign load     = ctrl_i.enq & ~valid_q & prv_valid_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (take_nxt) begin
      valid_d = nxt_valid_i;
      data_d  = nxt_data_i;
    end else if (load) begin
      valid_d = 1'b1;
      data_d  = ctrl_i.handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ tb/fifo_queue_with_remove_by_value_tb.sv @@
`timescale 1ns / 1ps

module fifo_queue_with_remove_by_value_tb;

  localparam int RandomCmds = 1300;

  typedef struct {
    fqr_pkg::action_e            act;
    logic [fqr_pkg::ItemW-1:0]   handle;
  } cmd_t;

  typedef struct {
    fqr_pkg::status_e            status;
    logic [fqr_pkg::ItemW-1:0]   item;
    logic [fqr_pkg::CountW-1:0]  count;
    logic                        empty;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  // command side
  logic                       start_r  = 1'b0;
  logic [fqr_pkg::ActW-1:0]   action_r = '0;
  logic [fqr_pkg::ItemW-1:0]  handle_r = '0;
  logic                       busy;

  // result side
  logic                       valid_o;
  logic [fqr_pkg::StatW-1:0]  status_o;
  logic [fqr_pkg::ItemW-1:0]  item_out_o;
  logic [fqr_pkg::CountW-1:0] count_o;
  logic                       is_empty_o;

  cmd_t                        pending_cmds[$];
  outcome_t                    awaited_outcomes[$];
  logic [fqr_pkg::HandleW-1:0] held_handles[$];

  int sent_cnt     = 0;
  int checked_cnt  = 0;
  int mismatch_cnt = 0;
  int full_cnt     = 0;
  int missing_cnt  = 0;
  int empty_cnt    = 0;
  int peak_count   = 0;
  int burst_left   = 8;
  int gap_left     = 0;

  fifo_queue_with_remove_by_value dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .start        (start_r),
    .action_i     (action_r),
    .item_handle_i(handle_r),
    .busy         (busy),
    .valid_o      (valid_o),
    .status_o     (status_o),
    .item_out_o   (item_out_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // applies one command to the shadow queue and returns what the block must report
  function automatic outcome_t queue_outcome(cmd_t c);
    outcome_t o;
    int       hit;
    o.status = fqr_pkg::ST_OK;
    o.item   = '0;
    hit      = -1;
    case (c.act)
      fqr_pkg::ACT_ENQ: begin
        if (held_handles.size() >= fqr_pkg::Depth) o.status = fqr_pkg::ST_FULL;
        else held_handles.push_back(c.handle);
      end
      fqr_pkg::ACT_DEQ: begin
        if (held_handles.size() == 0) o.status = fqr_pkg::ST_EMPTY;
        else o.item = held_handles.pop_front();
      end
      fqr_pkg::ACT_REM: begin
        if (held_handles.size() == 0) begin
          o.status = fqr_pkg::ST_EMPTY;
        end else begin
          // only the match nearest the head goes
          foreach (held_handles[k]) begin
            if (hit < 0 && held_handles[k] == c.handle) hit = k;
          end
          if (hit < 0) o.status = fqr_pkg::ST_MISSING;
          else held_handles.delete(hit);
        end
      end
      default: ;
    endcase
    o.count = fqr_pkg::CountW'(held_handles.size());
    o.empty = (held_handles.size() == 0);
    return o;
  endfunction

  function automatic void add_cmd(fqr_pkg::action_e a, logic [fqr_pkg::ItemW-1:0] h);
    cmd_t c;
    c.act    = a;
    c.handle = h;
    pending_cmds.push_back(c);
  endfunction

  // driver: bursts of commands with random gaps in between
  always @(posedge clk_i) begin
    logic nxt_start;
    if (!rst_n) begin
      start_r <= 1'b0;
    end else begin
      nxt_start = start_r;
      if (start_r && !busy) begin
        awaited_outcomes.push_back(queue_outcome(pending_cmds.pop_front()));
        sent_cnt++;
        nxt_start = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 7);
        end
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          nxt_start = 1'b1;
          action_r <= pending_cmds[0].act;
          handle_r <= pending_cmds[0].handle;
        end
      end
      start_r <= nxt_start;
    end
  end

  // monitor: every result beat against the oldest awaited outcome
  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_n && valid_o) begin
      if (awaited_outcomes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected beat: status %0d item %h count %0d empty %0b",
                   $realtime, status_o, item_out_o, count_o, is_empty_o);
      end else begin
        o = awaited_outcomes.pop_front();
        checked_cnt++;
        if (o.status == fqr_pkg::ST_FULL) full_cnt++;
        if (o.status == fqr_pkg::ST_MISSING) missing_cnt++;
        if (o.status == fqr_pkg::ST_EMPTY) empty_cnt++;
        if (int'(o.count) > peak_count) peak_count = int'(o.count);
        if (status_o !== o.status || item_out_o !== o.item ||
            count_o !== o.count || is_empty_o !== o.empty) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: exp st %0d item %h cnt %0d emp %0b, got st %0d item %h cnt %0d emp %0b",
                     $realtime, o.status, o.item, o.count, o.empty,
                     status_o, item_out_o, count_o, is_empty_o);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [fqr_pkg::ItemW-1:0] pool[10];
    int                        phase_left;
    int                        mode;
    int                        pick;
    logic [fqr_pkg::ItemW-1:0] h;

    // corner cases on an empty queue
    add_cmd(fqr_pkg::ACT_QUERY, 32'hFFFF_FFFF);
    add_cmd(fqr_pkg::ACT_DEQ, '0);
    add_cmd(fqr_pkg::ACT_REM, 32'h0000_0000);
    // handle zero, all ones and duplicates
    add_cmd(fqr_pkg::ACT_ENQ, 32'h0000_0000);
    add_cmd(fqr_pkg::ACT_ENQ, 32'hFFFF_FFFF);
    add_cmd(fqr_pkg::ACT_ENQ, 32'hA5A5_5A5A);
    add_cmd(fqr_pkg::ACT_ENQ, 32'h1234_5678);
    add_cmd(fqr_pkg::ACT_ENQ, 32'hA5A5_5A5A);
    add_cmd(fqr_pkg::ACT_REM, 32'hA5A5_5A5A);
    add_cmd(fqr_pkg::ACT_REM, 32'h5A5A_A5A5);
    add_cmd(fqr_pkg::ACT_DEQ, 32'hFFFF_FFFF);
    add_cmd(fqr_pkg::ACT_QUERY, '0);
    // fill up and knock on the full queue
    for (int i = 0; i < 13; i++) add_cmd(fqr_pkg::ACT_ENQ, $urandom);
    add_cmd(fqr_pkg::ACT_ENQ, 32'hDEAD_BEEF);
    add_cmd(fqr_pkg::ACT_REM, 32'hA5A5_5A5A);

    // random part: phases that lean toward filling, draining or neither
    phase_left = 0;
    mode       = 0;
    for (int n = 0; n < RandomCmds; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 160);
        mode       = $urandom_range(0, 2);
        foreach (pool[k]) pool[k] = $urandom;
        pool[0] = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      h    = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 9)];
      case (mode)
        0: begin
          if (pick < 60) add_cmd(fqr_pkg::ACT_ENQ, h);
          else if (pick < 75) add_cmd(fqr_pkg::ACT_DEQ, h);
          else if (pick < 95) add_cmd(fqr_pkg::ACT_REM, h);
          else add_cmd(fqr_pkg::ACT_QUERY, h);
        end
        1: begin
          if (pick < 20) add_cmd(fqr_pkg::ACT_ENQ, h);
          else if (pick < 60) add_cmd(fqr_pkg::ACT_DEQ, h);
          else if (pick < 95) add_cmd(fqr_pkg::ACT_REM, h);
          else add_cmd(fqr_pkg::ACT_QUERY, h);
        end
        default: begin
          if (pick < 40) add_cmd(fqr_pkg::ACT_ENQ, h);
          else if (pick < 65) add_cmd(fqr_pkg::ACT_DEQ, h);
          else if (pick < 90) add_cmd(fqr_pkg::ACT_REM, h);
          else add_cmd(fqr_pkg::ACT_QUERY, h);
        end
      endcase
    end

    // hold reset low, then release it
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || start_r) @(posedge clk_i);
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("commands sent %0d, results checked %0d, mismatches %0d",
             sent_cnt, checked_cnt, mismatch_cnt);
    $display("full refusals %0d, not found %0d, empty status %0d, peak count %0d",
             full_cnt, missing_cnt, empty_cnt, peak_count);
    if (mismatch_cnt == 0 && awaited_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("timeout with %0d commands pending and %0d results awaited",
             pending_cmds.size(), awaited_outcomes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/fqr_pkg.sv
rtl/core/fqr_cell.sv
rtl/core/fifo_queue_with_remove_by_value.sv
tb/fifo_queue_with_remove_by_value_tb.sv
